// ===== rtl/core/lateral_zmp_autocal_core_assert.svh =====
// assertion macros for the lateral zmp core
`ifndef LATERAL_ZMP_AUTOCAL_CORE_ASSERT_SVH
`define LATERAL_ZMP_AUTOCAL_CORE_ASSERT_SVH
// implication check under synchronous reset
`define LZA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lateral zmp check failed");
// next-cycle implication check under synchronous reset
`define LZA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lateral zmp check failed");
`endif

// ===== rtl/core/lza_pkg.sv =====
// ----------------------------------------------------------------------------
// lza_pkg
// shared constants and types for the lateral zmp core
// ----------------------------------------------------------------------------
package lza_pkg;
  localparam int NumSensors    = 8;
  localparam int ReadingWidth  = 16;
  localparam int RatioFracBits = 14;
  localparam int TotalOutWidth = 27;
  localparam int ZmpWidth      = 18;
  localparam logic [15:0] MaxReset = 16'd102;
  localparam logic [15:0] CapReset = 16'd5120;
  localparam int WeightWide    = 83886;
  localparam int WeightNarrow  = 31457;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LANES,
    ST_MERGE,
    ST_OUT
  } state_t;

  // lateral weight of a sensor, left positive
  function automatic logic signed [17:0] lateral_weight(input logic [2:0] idx);
    logic signed [17:0] w;
    case (idx)
      3'd0, 3'd2: w = 18'(WeightWide);
      3'd1, 3'd3: w = 18'(WeightNarrow);
      3'd4, 3'd6: w = -18'(WeightNarrow);
      default:    w = -18'(WeightWide);
    endcase
    return w;
  endfunction
endpackage

// ===== rtl/core/lza_divider.sv =====
// ----------------------------------------------------------------------------
// lza_divider
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lza_divider #(
  parameter int NumWidth = 30,
  parameter int DenWidth = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NumWidth-1:0] numer,
  input  logic [DenWidth-1:0] denom,
  output logic                busy,
  output logic                done,
  output logic [NumWidth-1:0] quot
);
  localparam int CntWidth = $clog2(NumWidth + 1);

  logic [DenWidth-1:0] den;
  logic [DenWidth:0]   rem;
  logic [CntWidth-1:0] cnt;
  logic [DenWidth:0]   shifted;
  logic [DenWidth:0]   diff;

  assign shifted = {rem[DenWidth-1:0], quot[NumWidth-1]};
  assign diff    = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntWidth'(NumWidth);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntWidth'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= numer;
      rem  <= '0;
      den  <= (denom == '0) ? DenWidth'(1) : denom;
    end else if (busy) begin
      if (!diff[DenWidth]) begin
        rem  <= diff;
        quot <= {quot[NumWidth-2:0], 1'b1};
      end else begin
        rem  <= shifted;
        quot <= {quot[NumWidth-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== rtl/core/lza_lane.sv =====
// ----------------------------------------------------------------------------
// lza_lane
// one sensor: running maximum update and serial ratio division
// ----------------------------------------------------------------------------
module lza_lane #(
  parameter int RatioFracBits = lza_pkg::RatioFracBits
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [15:0]                         reading,
  input  logic [15:0]                         cap,
  output logic                                done,
  output logic [16+RatioFracBits-1:0]         ratio
);
  localparam int NumWidth = 16 + RatioFracBits;

  logic [15:0] maximum;
  logic [15:0] max_next;
  logic        busy;

  always_comb begin
    max_next = maximum;
    if (maximum < reading && maximum < cap) max_next = reading;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      maximum <= lza_pkg::MaxReset;
    end else if (start) begin
      maximum <= max_next;
    end
  end

  lza_divider #(.NumWidth(NumWidth), .DenWidth(16)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .numer ({reading, {RatioFracBits{1'b0}}}),
    .denom (max_next),
    .busy  (busy),
    .done  (done),
    .quot  (ratio)
  );

  `include "lateral_zmp_autocal_core_assert.svh"
  `LZA_ASSERT_NXT(a_max_never_falls, start, maximum >= $past(maximum))
  `LZA_ASSERT_IMP(a_max_nonzero, 1'b1, maximum != 16'd0)
  `LZA_ASSERT_NXT(a_start_busy, start, busy)
endmodule

// ===== rtl/core/lza_merge.sv =====
// ----------------------------------------------------------------------------
// lza_merge
// accumulates lane ratios and moments, then divides moment by total unless total is zero
// ----------------------------------------------------------------------------
module lza_merge #(
  parameter int RatioFracBits = lza_pkg::RatioFracBits
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          start,
  input  logic [lza_pkg::NumSensors-1:0][16+RatioFracBits-1:0] ratios,
  output logic                                          done,
  output logic signed [lza_pkg::ZmpWidth-1:0]           zmp,
  output logic [lza_pkg::TotalOutWidth-1:0]             total_sat,
  output logic                                          nonzero
);
  localparam int RW = 16 + RatioFracBits;
  localparam int TW = RW + 3;
  localparam int MW = TW + 18;

  logic [2:0]           idx;
  logic                 accum;
  logic [TW-1:0]        total;
  logic signed [MW-1:0] moment;
  logic signed [RW+18:0] prod;
  logic                 div_start;
  logic                 div_busy;
  logic                 div_done;
  logic [MW-1:0]        quot;
  logic [MW-1:0]        mag;
  logic                 neg;
  logic [MW-1:0]        sq;

  assign prod = $signed({1'b0, ratios[idx]}) * lza_pkg::lateral_weight(idx);
  assign mag  = moment[MW-1] ? MW'(-moment) : MW'(moment);

  always_ff @(posedge clk) begin
    if (rst) begin
      accum     <= 1'b0;
      idx       <= '0;
      div_start <= 1'b0;
      done      <= 1'b0;
    end else begin
      div_start <= 1'b0;
      done      <= 1'b0;
      if (start) begin
        accum <= 1'b1;
        idx   <= '0;
      end else if (accum) begin
        idx <= idx + 1'b1;
        if (idx == 3'd7) begin
          accum <= 1'b0;
          if (total + TW'(ratios[idx]) == '0) done <= 1'b1;
          else div_start <= 1'b1;
        end
      end
      if (div_done) done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      total  <= '0;
      moment <= '0;
    end else if (accum) begin
      total  <= total + TW'(ratios[idx]);
      moment <= moment + MW'(prod);
    end
    if (div_start) neg <= moment[MW-1];
  end

  lza_divider #(.NumWidth(MW), .DenWidth(TW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (mag),
    .denom (total),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (quot)
  );

  assign sq        = neg ? -quot : quot;
  assign nonzero   = total != '0;
  assign zmp       = nonzero ? sq[lza_pkg::ZmpWidth-1:0] : '0;
  assign total_sat = (total > TW'({lza_pkg::TotalOutWidth{1'b1}}))
                     ? {lza_pkg::TotalOutWidth{1'b1}}
                     : lza_pkg::TotalOutWidth'(total);

  `include "lateral_zmp_autocal_core_assert.svh"
  `LZA_ASSERT_IMP(a_no_overlap, div_busy, !accum)
  `LZA_ASSERT_IMP(a_done_excl, div_done, !accum)
endmodule

// ===== rtl/core/lateral_zmp_autocal_core.sv =====
// ----------------------------------------------------------------------------
// lateral_zmp_autocal_core
// lateral zero moment point from eight self-calibrating foot force sensors
// ----------------------------------------------------------------------------
// channel   | dir | fields
// s_axis    | in  | tdata: eight 16-bit readings, lfl in lowest bits
// m_axis    | out | tdata: zmp_lateral[17:0], total_pressure[44:18], pressure_valid[45]
// cfg       | in  | cfg_wr_en / cfg_wr_data: calibration cap
//
// eight lanes divide in parallel; merge then sums the eight ratios and moments in turn
// and divides moment by total
// nonzero total: the result follows the lane divides, the merge sum and the merge divide
// zero total skips the merge divide
// one item at a time; s_axis_tready is low until the result is taken
// output register holds the result while m_axis_tready is low
// synchronous active-high reset restores maxima to 0.1 kg and cap to 5.0 kg
module lateral_zmp_autocal_core #(
  parameter int RatioFracBits = lza_pkg::RatioFracBits
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // lfl, lfr, lrl, lrr, rfl, rfr, rrl, rrr
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [47:0]  m_axis_tdata,  // zmp_lateral, total_pressure, pressure_valid
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data
);
  localparam int RW = 16 + RatioFracBits;

  lza_pkg::state_t state, state_next;
  logic [15:0] cap;
  logic        start;
  logic        merge_start;
  logic        merge_done;
  logic [lza_pkg::NumSensors-1:0] lane_done;
  logic [lza_pkg::NumSensors-1:0][RW-1:0] ratios;
  logic signed [lza_pkg::ZmpWidth-1:0] zmp;
  logic [lza_pkg::TotalOutWidth-1:0] total_sat;
  logic nonzero;

  // calibration cap register
  always_ff @(posedge clk) begin
    if (rst) cap <= lza_pkg::CapReset;
    else if (cfg_wr_en) cap <= cfg_wr_data;
  end

  assign start         = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == lza_pkg::ST_IDLE);
  assign m_axis_tvalid = (state == lza_pkg::ST_OUT);
  assign merge_start   = (state == lza_pkg::ST_LANES) && lane_done[0];

  always_ff @(posedge clk) begin
    if (rst) state <= lza_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lza_pkg::ST_IDLE:  if (start) state_next = lza_pkg::ST_LANES;
      lza_pkg::ST_LANES: if (lane_done[0]) state_next = lza_pkg::ST_MERGE;
      lza_pkg::ST_MERGE: if (merge_done) state_next = lza_pkg::ST_OUT;
      lza_pkg::ST_OUT:   if (m_axis_tready) state_next = lza_pkg::ST_IDLE;
      default:           state_next = lza_pkg::ST_IDLE;
    endcase
  end

  // sensor lanes
  for (genvar i = 0; i < lza_pkg::NumSensors; i++) begin : g_lane
    lza_lane #(.RatioFracBits(RatioFracBits)) u_lane (
      .clk     (clk),
      .rst     (rst),
      .start   (start),
      .reading (s_axis_tdata[16*i +: 16]),
      .cap     (cap),
      .done    (lane_done[i]),
      .ratio   (ratios[i])
    );
  end

  lza_merge #(.RatioFracBits(RatioFracBits)) u_merge (
    .clk       (clk),
    .rst       (rst),
    .start     (merge_start),
    .ratios    (ratios),
    .done      (merge_done),
    .zmp       (zmp),
    .total_sat (total_sat),
    .nonzero   (nonzero)
  );

  // merge results hold until next start, so they serve as the output register
  assign m_axis_tdata = {2'b00, nonzero, total_sat, zmp};

  `include "lateral_zmp_autocal_core_assert.svh"
  `LZA_ASSERT_IMP(a_lanes_lockstep, lane_done[0], lane_done == '1)
  `LZA_ASSERT_NXT(a_out_holds, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `LZA_ASSERT_IMP(a_zero_total, m_axis_tvalid && !m_axis_tdata[45], m_axis_tdata[17:0] == '0)
endmodule

// ===== bench/lateral_zmp_autocal_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lateral_zmp_autocal_core_tb
// drives sensor samples through the lateral zmp core and checks every result
// against a cycle-free predictor of the calibrating maxima and the zmp divide
// ----------------------------------------------------------------------------
module lateral_zmp_autocal_core_tb;

  localparam int RandItems = 1450;
  localparam int IdleLimit = 20000;
  localparam int HoldCycles = 3000;

  typedef struct packed {
    logic                              valid;
    logic [lza_pkg::TotalOutWidth-1:0] total;
    logic [lza_pkg::ZmpWidth-1:0]      zmp;
  } zmp_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;  // lfl, lfr, lrl, lrr, rfl, rfr, rrl, rrr
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;       // zmp_lateral, total_pressure, pressure_valid
  logic         cfg_wr_en = 1'b0;
  logic [15:0]  cfg_wr_data = '0;

  lateral_zmp_autocal_core u_top (.*);

  always #4 clk = ~clk;

  // predictor state
  logic [15:0]  max_model [lza_pkg::NumSensors];
  logic [15:0]  cap_model;

  logic [127:0] sample_q [$];
  zmp_result_t  zmp_expect_q [$];
  int           fail_count = 0;
  int           idle_cycles = 0;
  bit           rx_hold_req = 1'b0;
  bit           rx_hold_seen = 1'b0;
  int           rx_hold_left = 0;

  // predict one sample: updates the maxima and returns the expected beat
  function automatic zmp_result_t predict_zmp(input logic [127:0] sample);
    zmp_result_t       r;
    logic [15:0]       rd;
    longint unsigned   q, total;
    longint            moment, w;
    total  = 0;
    moment = 0;
    for (int i = 0; i < lza_pkg::NumSensors; i++) begin
      rd = sample[16*i +: 16];
      if (max_model[i] < rd && max_model[i] < cap_model) max_model[i] = rd;
      q = (longint'(rd) << lza_pkg::RatioFracBits) /
          ((max_model[i] == 0) ? 1 : max_model[i]);
      w = (i == 0 || i == 2) ? lza_pkg::WeightWide :
          (i == 1 || i == 3) ? lza_pkg::WeightNarrow :
          (i == 4 || i == 6) ? -lza_pkg::WeightNarrow : -lza_pkg::WeightWide;
      total  += q;
      moment += w * longint'(q);
    end
    r.valid = (total != 0);
    r.total = (total > 134217727) ? 27'h7FFFFFF : total[lza_pkg::TotalOutWidth-1:0];
    r.zmp   = (total != 0) ? lza_pkg::ZmpWidth'(moment / longint'(total)) : '0;
    return r;
  endfunction

  // driver: bursts of random length with random gaps, never drops tvalid mid-beat
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) void'(sample_q.pop_front());
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the beat
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else begin
        // queue head after the pop above
        if (sample_q.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= sample_q[0];
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 200);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off counted here
  always @(posedge clk) begin
    if (rx_hold_req && !rx_hold_seen) begin
      rx_hold_seen  <= 1'b1;
      rx_hold_left  <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left  <= rx_hold_left - 1;
      m_axis_tready <= 1'b0;
    end else case ($urandom_range(0, 3))
      0: m_axis_tready <= 1'b0;
      1: m_axis_tready <= ($urandom_range(0, 1) == 1);
      default: m_axis_tready <= 1'b1;
    endcase
  end

  // monitor: predicts on input beats, checks on output beats
  zmp_result_t got;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) zmp_expect_q.push_back(predict_zmp(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[45], m_axis_tdata[44:18], m_axis_tdata[17:0]};
        if (zmp_expect_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
          fail_count++;
        end else begin
          if (got.zmp !== zmp_expect_q[0].zmp) begin
            $display("%0t: zmp_lateral exp %h got %h", $time, zmp_expect_q[0].zmp, got.zmp);
            fail_count++;
          end
          if (got.total !== zmp_expect_q[0].total) begin
            $display("%0t: total_pressure exp %h got %h", $time,
                     zmp_expect_q[0].total, got.total);
            fail_count++;
          end
          if (got.valid !== zmp_expect_q[0].valid) begin
            $display("%0t: pressure_valid exp %b got %b", $time,
                     zmp_expect_q[0].valid, got.valid);
            fail_count++;
          end
          void'(zmp_expect_q.pop_front());
        end
      end
      // watchdog on accepted beats
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic drain_all();
    wait (sample_q.size() == 0 && !s_axis_tvalid && zmp_expect_q.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_cap(input logic [15:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cap_model = v;
  endtask

  // random sample: mostly plausible kilogram readings, sometimes extremes
  function automatic logic [127:0] rand_sample();
    logic [127:0] s;
    for (int i = 0; i < lza_pkg::NumSensors; i++)
      case ($urandom_range(0, 9))
        0: s[16*i +: 16] = 16'd0;
        1: s[16*i +: 16] = 16'($urandom_range(0, 65535));
        2: s[16*i +: 16] = 16'($urandom_range(0, 150));
        default: s[16*i +: 16] = 16'($urandom_range(0, 8000));
      endcase
    return s;
  endfunction

  task automatic push_rand(input int n);
    for (int k = 0; k < n; k++) sample_q.push_back(rand_sample());
  endtask

  initial begin
    logic [15:0] caps [5];
    for (int i = 0; i < lza_pkg::NumSensors; i++) max_model[i] = lza_pkg::MaxReset;
    cap_model = lza_pkg::CapReset;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: zero sample, all ones, one sensor at a time, below reset maximum
    sample_q.push_back('0);
    sample_q.push_back({8{16'd50}});
    for (int i = 0; i < lza_pkg::NumSensors; i++)
      sample_q.push_back(128'(16'd3000) << (16 * i));
    sample_q.push_back({8{16'hFFFF}});
    sample_q.push_back({8{16'd5120}});
    sample_q.push_back({{4{16'd0}}, {4{16'd4000}}});
    sample_q.push_back({{4{16'd4000}}, {4{16'd0}}});
    sample_q.push_back({8{16'd1}});
    sample_q.push_back({16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                        16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
    drain_all();

    // long receiver hold-off while the sender keeps offering
    rx_hold_req = 1'b1;
    push_rand(20);
    wait (rx_hold_seen);
    @(posedge clk);
    wait (rx_hold_left == 0);
    drain_all();

    // reset-state maxima are gone, so the cap settings act on fresh growth only
    caps = '{16'd0, 16'd101, 16'hFFFF, 16'd800, lza_pkg::CapReset};
    foreach (caps[c]) begin
      write_cap(caps[c]);
      push_rand(RandItems / 5);
      drain_all();
    end

    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/lza_pkg.sv
rtl/core/lza_divider.sv
rtl/core/lza_lane.sv
rtl/core/lza_merge.sv
rtl/core/lateral_zmp_autocal_core.sv
bench/lateral_zmp_autocal_core_tb.sv
